### rtl/core/tclru_pkg.sv
// ----------------------------------------------------------------------------
// tclru_pkg
// Shared types and constants for the LRU trace cache.
// ----------------------------------------------------------------------------
package tclru_pkg;

    localparam int SET_COUNT    = 64;
    localparam int WAY_COUNT    = 4;
    localparam int LINE_OFS     = 2;
    localparam int MAX_BRANCHES = 3;

    localparam int SET_W  = $clog2(SET_COUNT);
    localparam int WAY_W  = 2;
    localparam int TAG_W  = 32 - LINE_OFS - SET_W;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_FETCH = 2'd1,
        OP_FILL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] pc;
        logic [2:0]  pred_flags;
        logic [2:0]  fill_flags;
        logic [1:0]  fill_branch_count;
        logic [31:0] fill_taken;
        logic [31:0] fill_fall;
        logic        fill_ends;
        logic [63:0] fill_payload;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way;
        logic        evicted;
        logic [63:0] payload;
        logic [31:0] taken_target;
        logic [31:0] fall_target;
        logic        ends_in_branch;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

    // entry metadata: tag, flags, count, ends_branch
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [2:0]       flags;
        logic [1:0]       count;
        logic             ends;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [31:0] taken;
        logic [31:0] fall;
        logic [63:0] contents;
    } entry_t;

endpackage

### rtl/core/trace_cache_lru_lookup_fill_top.sv
// ----------------------------------------------------------------------------
// trace_cache_lru_lookup_fill_top
// Four-way set-associative trace cache with true-LRU order per set.
// ----------------------------------------------------------------------------
// Use:
//   s_axis carries one request item (probe, fetch or fill), the operation
//   in tuser; m_axis returns exactly one result item for each, hit in tuser.
//   An accepted item is latched and its set read in the load cycle; the
//   read-modify-write of tags, valid bits and LRU order follows in the next
//   cycle, and the result is then held on m_axis. No new item is taken
//   during the lookup; a new item is taken in the same cycle the held
//   result is taken.
//   Reset clears all valid bits and sets each set's LRU order to highest way
//   most recent; no clearing pass is needed.
//   When m_axis_tready is low the result is held and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module trace_cache_lru_lookup_fill_top
    import tclru_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation
    input  logic [1:0]   s_axis_tuser,
    // pc, pred_flags, fill_flags, fill_branch_count,
    // fill_taken, fill_fall, fill_ends, fill_payload, 7 pad
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit
    output logic         m_axis_tuser,
    // way, evicted, payload, taken_target, fall_target, ends_in_branch, 4 pad
    output logic [135:0] m_axis_tdata
);

    cmd_t cmd;
    req_t req;
    rsp_t rsp;

    assign req.operation         = s_axis_tuser;
    assign req.pc                = s_axis_tdata[31:0];
    assign req.pred_flags        = s_axis_tdata[34:32];
    assign req.fill_flags        = s_axis_tdata[37:35];
    assign req.fill_branch_count = s_axis_tdata[39:38];
    assign req.fill_taken        = s_axis_tdata[71:40];
    assign req.fill_fall         = s_axis_tdata[103:72];
    assign req.fill_ends         = s_axis_tdata[104];
    assign req.fill_payload      = s_axis_tdata[168:105];

    assign m_axis_tuser = rsp.hit;
    assign m_axis_tdata = {4'd0, rsp.ends_in_branch, rsp.fall_target, rsp.taken_target,
                           rsp.payload, rsp.evicted, rsp.way};

    tclru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    tclru_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

### rtl/core/tclru_ctrl.sv
// ----------------------------------------------------------------------------
// tclru_ctrl
// Sequencer: load item, commit lookup/update, hold result.
// ----------------------------------------------------------------------------
module tclru_ctrl
    import tclru_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // next item accepted while the result is taken
                if (out_ready)
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/tclru_dp.sv
// ----------------------------------------------------------------------------
// tclru_dp
// Tag/data arrays, valid bits, per-set LRU order, hit and victim logic.
// ----------------------------------------------------------------------------
module tclru_dp
    import tclru_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output rsp_t rsp
);

    localparam int ORD_W = WAY_COUNT * WAY_W;

    entry_t               mem [SET_COUNT][WAY_COUNT];
    logic [WAY_COUNT-1:0] valid_reg [SET_COUNT];
    logic [ORD_W-1:0]     order_reg [SET_COUNT];

    req_t   req_reg;
    entry_t rd_reg [WAY_COUNT];
    logic [WAY_COUNT-1:0] rv_reg;
    logic [ORD_W-1:0]     ro_reg;
    rsp_t   rsp_reg, rsp_next;

    logic [SET_W-1:0] set_in, set_r;
    logic [TAG_W-1:0] tag_r;

    assign set_in = req.pc[LINE_OFS +: SET_W];
    assign set_r  = req_reg.pc[LINE_OFS +: SET_W];
    assign tag_r  = req_reg.pc[31 -: TAG_W];

    // load: latch item and read the set
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            for (int w = 0; w < WAY_COUNT; w++)
                rd_reg[w] <= mem[set_in][w];
            rv_reg <= valid_reg[set_in];
            ro_reg <= order_reg[set_in];
        end
    end

    // hit / victim
    logic [WAY_COUNT-1:0] match;
    logic                 any_hit, any_inv;
    logic [WAY_W-1:0]     hit_w, inv_w, sel_w;
    logic [2:0]           mask;
    logic [1:0]           cnt;
    logic [ORD_W-1:0]     ord_next;
    logic [WAY_W-1:0]     pos;
    op_t                  op;

    assign op = op_t'(req_reg.operation);

    always_comb
    begin
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            cnt  = (rd_reg[w].meta.count > 2'(MAX_BRANCHES)) ? 2'(MAX_BRANCHES)
                                                             : rd_reg[w].meta.count;
            mask = 3'((4'd1 << cnt) - 4'd1);
            match[w] = rv_reg[w] && (rd_reg[w].meta.tag == tag_r) &&
                       ((rd_reg[w].meta.flags & mask) == req_reg.pred_flags);
        end
        any_hit = 1'b0;
        hit_w   = '0;
        any_inv = 1'b0;
        inv_w   = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                any_hit = 1'b1;
                hit_w   = WAY_W'(w);
            end
            if (!rv_reg[w])
            begin
                any_inv = 1'b1;
                inv_w   = WAY_W'(w);
            end
        end
        sel_w = (op == OP_FILL) ? (any_inv ? inv_w : ro_reg[ORD_W-1 -: WAY_W]) : hit_w;
        // move sel_w to front
        pos = WAY_W'(WAY_COUNT - 1);
        for (int i = WAY_COUNT - 1; i >= 0; i--)
            if (ro_reg[i*WAY_W +: WAY_W] == sel_w)
                pos = WAY_W'(i);
        ord_next = ro_reg;
        for (int i = 1; i < WAY_COUNT; i++)
            if (WAY_W'(i) <= pos)
                ord_next[i*WAY_W +: WAY_W] = ro_reg[(i-1)*WAY_W +: WAY_W];
        ord_next[0 +: WAY_W] = sel_w;
    end

    logic do_fill, do_mru;
    assign do_fill = cmd.commit && (op == OP_FILL);
    assign do_mru  = cmd.commit && (do_fill || (op == OP_FETCH && any_hit));

    entry_t wr_e;
    always_comb
    begin
        wr_e.meta.tag   = tag_r;
        wr_e.meta.flags = req_reg.fill_flags;
        wr_e.meta.count = req_reg.fill_branch_count;
        wr_e.meta.ends  = req_reg.fill_ends;
        wr_e.taken      = req_reg.fill_taken;
        wr_e.fall       = req_reg.fill_fall;
        wr_e.contents   = req_reg.fill_payload;
    end

    always_ff @(posedge clk)
    begin
        if (do_fill)
            mem[set_r][sel_w] <= wr_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SET_COUNT; s++)
            begin
                valid_reg[s] <= '0;
                for (int i = 0; i < WAY_COUNT; i++)
                    order_reg[s][i*WAY_W +: WAY_W] <= WAY_W'(WAY_COUNT - 1 - i);
            end
        end
        else
        begin
            if (do_fill)
                valid_reg[set_r][sel_w] <= 1'b1;
            if (do_mru)
                order_reg[set_r] <= ord_next;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if ((op == OP_PROBE || op == OP_FETCH) && any_hit)
        begin
            rsp_next.hit            = 1'b1;
            rsp_next.way            = hit_w;
            rsp_next.payload        = rd_reg[hit_w].contents;
            rsp_next.taken_target   = rd_reg[hit_w].taken;
            rsp_next.fall_target    = rd_reg[hit_w].fall;
            rsp_next.ends_in_branch = rd_reg[hit_w].meta.ends;
        end
        else if (op == OP_FILL)
        begin
            rsp_next.way     = sel_w;
            rsp_next.evicted = !any_inv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

### rtl/core/tclru_checker.sv
// ----------------------------------------------------------------------------
// tclru_assert
// Port-level checks for the trace cache top level.
// ----------------------------------------------------------------------------
module tclru_assert
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic [175:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic         m_axis_tuser,
    input logic [135:0] m_axis_tdata
);

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid ##1 m_axis_tvalid)
        else $error("result not two cycles after item");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("item taken while result stalled");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tuser)
        else $error("evicted and hit together");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind trace_cache_lru_lookup_fill_top tclru_assert u_chk (.*);

### bench/tclru_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tclru_checker
// Watches both item channels of the trace cache, keeps its own copy of the
// tags, trace fields and LRU order, and compares every result item with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module tclru_checker
    import tclru_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,
    input  logic [175:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         m_axis_tuser,
    input  logic [135:0] m_axis_tdata,
    output int           mismatches,
    output int           outstanding
);

    typedef struct {
        logic        hit;
        logic [1:0]  way;
        logic        evicted;
        logic [63:0] payload;
        logic [31:0] taken;
        logic [31:0] fall;
        logic        ends;
    } lookup_t;

    logic        valid_q    [SET_COUNT][WAY_COUNT];
    logic [23:0] tag_q      [SET_COUNT][WAY_COUNT];
    logic [2:0]  flags_q    [SET_COUNT][WAY_COUNT];
    logic [1:0]  count_q    [SET_COUNT][WAY_COUNT];
    logic [31:0] taken_q    [SET_COUNT][WAY_COUNT];
    logic [31:0] fall_q     [SET_COUNT][WAY_COUNT];
    logic        ends_q     [SET_COUNT][WAY_COUNT];
    logic [63:0] contents_q [SET_COUNT][WAY_COUNT];
    logic [1:0]  lru_q      [SET_COUNT][WAY_COUNT];   // position 0 is MRU

    lookup_t pending_results[$];

    assign outstanding = pending_results.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void touch(input int set, input int w);
        int pos;
        pos = WAY_COUNT - 1;
        for (int i = WAY_COUNT - 1; i >= 0; i--)
            if (lru_q[set][i] == w) pos = i;
        for (int i = pos; i > 0; i--)
            lru_q[set][i] = lru_q[set][i-1];
        lru_q[set][0] = w[1:0];
    endfunction

    function automatic lookup_t predict_lookup(input logic [1:0] kind,
                                               input logic [175:0] d);
        lookup_t r;
        op_t         op;
        logic [5:0]  set;
        logic [23:0] tag;
        logic [2:0]  mask;
        int          victim;
        bit          found;
        r = '{default: '0};
        op = op_t'(kind);
        set = d[7:2];
        tag = d[31:8];
        if (op == OP_PROBE || op == OP_FETCH)
        begin
            for (int w = 0; w < WAY_COUNT; w++)
            begin
                mask = (3'd1 << count_q[set][w]) - 3'd1;
                if (!r.hit && valid_q[set][w] && tag_q[set][w] == tag
                    && (flags_q[set][w] & mask) == d[34:32])
                begin
                    r.hit = 1'b1;
                    r.way = w[1:0];
                    r.payload = contents_q[set][w];
                    r.taken = taken_q[set][w];
                    r.fall = fall_q[set][w];
                    r.ends = ends_q[set][w];
                    if (op == OP_FETCH) touch(set, w);
                end
            end
        end
        else if (op == OP_FILL)
        begin
            victim = lru_q[set][WAY_COUNT-1];
            found = 0;
            for (int w = WAY_COUNT - 1; w >= 0; w--)
                if (!valid_q[set][w])
                begin
                    victim = w;
                    found = 1;
                end
            r.way = victim[1:0];
            r.evicted = !found;
            valid_q[set][victim] = 1'b1;
            tag_q[set][victim] = tag;
            flags_q[set][victim] = d[37:35];
            count_q[set][victim] = d[39:38];
            taken_q[set][victim] = d[71:40];
            fall_q[set][victim] = d[103:72];
            ends_q[set][victim] = d[104];
            contents_q[set][victim] = d[168:105];
            touch(set, victim);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            pending_results.delete();
            for (int s = 0; s < SET_COUNT; s++)
                for (int w = 0; w < WAY_COUNT; w++)
                begin
                    valid_q[s][w] = 1'b0;
                    count_q[s][w] = '0;
                    flags_q[s][w] = '0;
                    lru_q[s][w] = 2'(WAY_COUNT - 1 - w);
                end
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result item %h", $realtime, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.hit) report("hit", m_axis_tuser, want.hit);
                    if (m_axis_tdata[1:0] !== want.way) report("way", m_axis_tdata[1:0], want.way);
                    if (m_axis_tdata[2] !== want.evicted)
                        report("evicted", m_axis_tdata[2], want.evicted);
                    if (m_axis_tdata[66:3] !== want.payload)
                        report("payload", m_axis_tdata[66:3], want.payload);
                    if (m_axis_tdata[98:67] !== want.taken)
                        report("taken target", m_axis_tdata[98:67], want.taken);
                    if (m_axis_tdata[130:99] !== want.fall)
                        report("fall-through", m_axis_tdata[130:99], want.fall);
                    if (m_axis_tdata[131] !== want.ends)
                        report("ends in branch", m_axis_tdata[131], want.ends);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_lookup(s_axis_tuser, s_axis_tdata));
        end
    end

endmodule

### bench/tb_trace_cache_lru_lookup_fill_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trace_cache_lru_lookup_fill_top
// Drives probes, fetches and fills over a small pool of addresses so that
// sets fill up, hit and evict, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_trace_cache_lru_lookup_fill_top
    import tclru_pkg::*;
;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;
    logic [175:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         m_axis_tuser;
    logic [135:0] m_axis_tdata;
    int           mismatches;
    int           outstanding;
    int           burst_left;
    logic [31:0]  pc_pool[16];

    trace_cache_lru_lookup_fill_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tdata (m_axis_tdata)
    );

    tclru_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver stall pattern: alternating phases of always-ready and random stalls
    always @(negedge clk)
    begin
        int phase;
        phase = (int'($time) / 2000) % 3;
        if (phase == 0) m_axis_tready <= 1'b1;
        else if (phase == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 2) == 0);
    end

    task automatic send(input op_t op, input logic [31:0] pc, input logic [2:0] req,
                        input logic [2:0] flags, input logic [1:0] cnt,
                        input logic [31:0] taken, input logic [31:0] fall,
                        input logic ends, input logic [63:0] payload);
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'd0, payload, ends, fall, taken, cnt, flags, req, pc};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random();
        int     k;
        op_t    op;
        logic [31:0] pc;
        k = $urandom_range(0, 99);
        if (k < 30) op = OP_FILL;
        else if (k < 60) op = OP_PROBE;
        else if (k < 97) op = OP_FETCH;
        else op = OP_NONE;
        pc = ($urandom_range(0, 9) == 0) ? $urandom() : pc_pool[$urandom_range(0, 15)];
        send(op, pc, ($urandom_range(0, 1) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 1))),
             3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), $urandom(), $urandom(),
             1'($urandom_range(0, 1)), {$urandom(), $urandom()});
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        burst_left = 4;
        // few sets, several tags each, so sets overflow and evict
        for (int i = 0; i < 16; i++)
            pc_pool[i] = {$urandom_range(0, 5) == 0 ? 24'($urandom()) : 24'(i % 6),
                          6'($urandom_range(0, 2)), 2'($urandom_range(0, 3))};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(OP_PROBE, 32'h0, 3'd0, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FILL, 32'h0, 3'd0, 3'd5, 2'd3, 32'hFFFF_FFFF, 32'h0, 1'b1, '1);
        send(OP_PROBE, 32'h0, 3'd5, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_PROBE, 32'h0, 3'd4, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FETCH, 32'h3, 3'd5, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FETCH, 32'h0, 3'd7, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FILL, 32'hFFFF_FFFF, 3'd7, 3'd7, 2'd0, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
        send(OP_PROBE, 32'hFFFF_FFFF, 3'd0, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_PROBE, 32'hFFFF_FFFF, 3'd7, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FILL, 32'h100, 3'd0, 3'd6, 2'd1, 32'h1234, 32'h5678, 1'b1, 64'h55);
        send(OP_FILL, 32'h200, 3'd0, 3'd3, 2'd2, 32'h1, 32'h2, 1'b0, 64'h66);
        send(OP_FILL, 32'h300, 3'd0, 3'd7, 2'd3, 32'h3, 32'h4, 1'b1, 64'h77);
        send(OP_FETCH, 32'h100, 3'd0, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FETCH, 32'h0, 3'd5, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_FILL, 32'h400, 3'd0, 3'd1, 2'd1, 32'h9, 32'hA, 1'b0, 64'h88);
        send(OP_FILL, 32'h500, 3'd0, 3'd2, 2'd2, 32'hB, 32'hC, 1'b1, 64'h99);
        send(OP_PROBE, 32'h200, 3'd3, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_PROBE, 32'h300, 3'd7, 3'd0, 2'd0, '0, '0, 1'b0, '0);
        send(OP_NONE, 32'h0, 3'd5, 3'd7, 2'd3, '1, '1, 1'b1, '1);
        send(OP_PROBE, 32'h500, 3'd2, 3'd0, 2'd0, '0, '0, 1'b0, '0);

        repeat (530) send_random();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("** trace_cache_lru_lookup_fill_top: PASSED **");
        else
            $display("** trace_cache_lru_lookup_fill_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("** trace_cache_lru_lookup_fill_top: FAILED **");
        $finish;
    end

endmodule
